### hdl/aws_pkg.sv
// Shared types, constants and helpers of the autoshutdown window scheduler.
package aws_pkg;

  localparam int unsigned AddrW              = 5;
  localparam int unsigned DataW              = 32;
  localparam int unsigned MinsPerDay         = 1440;
  localparam int unsigned SecsPerDay         = 86400;
  localparam int unsigned LifetimeSecs       = 7 * 365 * SecsPerDay;
  localparam int unsigned DefaultBoardDate   = 804582000;
  localparam int unsigned WakeGuard          = 180;
  localparam int unsigned RetryWait          = 300;
  localparam int unsigned DefaultCycleLimit  = 10000;
  localparam int unsigned DefaultGraceCycles = DefaultCycleLimit / 10;
  localparam int unsigned DefaultSpan        = DefaultCycleLimit - DefaultGraceCycles;
  // floor(x / 10) == (x * Div10Mult) >> Div10Shift for any 20-bit x
  localparam int unsigned Div10Mult          = 838861;
  localparam int unsigned Div10Shift         = 23;

  typedef enum logic [2:0] {
    RegShutdownEnable   = 3'd0,
    RegIdleMinutes      = 3'd1,
    RegWindowStartMin   = 3'd2,
    RegWindowFinishMin  = 3'd3,
    RegScriptCheck      = 3'd4,
    RegAutowake         = 3'd5,
    RegWearBudget       = 3'd6,
    RegCycleLimit       = 3'd7
  } aws_reg_e;

  typedef enum logic [2:0] {
    OutDisabled  = 3'd0,
    OutOutside   = 3'd1,
    OutBusy      = 3'd2,
    OutWearHold  = 3'd3,
    OutWakeNear  = 3'd4,
    OutPowerOff  = 3'd5
  } aws_outcome_e;

  typedef struct packed {
    logic        shutdown_enable;
    logic [15:0] idle_minutes;
    logic [10:0] window_start_min;
    logic [10:0] window_finish_min;
    logic        script_check_enable;
    logic        autowake_enable;
    logic        wear_budget_enable;
    logic [19:0] cycle_limit;
    logic [16:0] grace_cycles;
    logic [19:0] span_cycles;
  } aws_cfg_t;

  typedef struct packed {
    logic [31:0]        now_time;
    logic [31:0]        day_begin;
    logic signed [31:0] kbd_idle;
    logic signed [31:0] mouse_idle;
    logic signed [31:0] system_idle;
    logic [30:0]        since_resume;
    logic [30:0]        script_idle;
    logic [19:0]        cycle_count;
    logic               cycle_count_known;
    logic [31:0]        board_date;
    logic               board_date_known;
  } aws_item_t;

  typedef struct packed {
    logic        enabled;
    logic        in_window;
    logic        busy;
    logic        wear_quick_ok;
    logic        passed_neg;
    logic [51:0] prod_budget;
    logic [47:0] prod_need;
    logic        autowake;
    logic        too_near;
    logic [31:0] wake_time;
    logic [31:0] next_pre;
    logic [31:0] next_wear;
    logic [31:0] next_near;
    logic [31:0] next_poff;
  } aws_mid_t;

  typedef struct packed {
    logic [31:0]  next_check;
    logic         power_off;
    logic         alarm_set;
    logic [31:0]  alarm_time;
    aws_outcome_e outcome;
  } aws_res_t;

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 36'sh0FFFFFFFF) begin
      r = '1;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [10:0] mod_day(input logic [10:0] m);
    logic [10:0] r;
    if (m >= 11'(MinsPerDay)) begin
      r = m - 11'(MinsPerDay);
    end else begin
      r = m;
    end
    return r;
  endfunction

endpackage

### hdl/aws_if.sv
// Valid/ready channel interfaces for evaluation words and result words.
interface aws_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_time;
  logic [31:0]        day_begin;
  logic signed [31:0] kbd_idle;
  logic signed [31:0] mouse_idle;
  logic signed [31:0] system_idle;
  logic [30:0]        since_resume;
  logic [30:0]        script_idle;
  logic [19:0]        cycle_count;
  logic               cycle_count_known;
  logic [31:0]        board_date;
  logic               board_date_known;

  modport source (
    output valid, now_time, day_begin, kbd_idle, mouse_idle, system_idle,
           since_resume, script_idle, cycle_count, cycle_count_known,
           board_date, board_date_known,
    input  ready
  );
  modport sink (
    input  valid, now_time, day_begin, kbd_idle, mouse_idle, system_idle,
           since_resume, script_idle, cycle_count, cycle_count_known,
           board_date, board_date_known,
    output ready
  );
endinterface

interface aws_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_check;
  logic        power_off;
  logic        alarm_set;
  logic [31:0] alarm_time;
  logic [2:0]  outcome;

  modport source (
    output valid, next_check, power_off, alarm_set, alarm_time, outcome,
    input  ready
  );
  modport sink (
    input  valid, next_check, power_off, alarm_set, alarm_time, outcome,
    output ready
  );
endinterface

### hdl/aws_cfg.sv
// APB configuration registers with derived wear-budget constants.
module aws_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [aws_pkg::AddrW-1:0] paddr,
  input  logic [aws_pkg::DataW-1:0] pwdata,
  output logic [aws_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output aws_pkg::aws_cfg_t         cfg_o
);

  logic        shutdown_enable_q;
  logic [15:0] idle_minutes_q;
  logic [10:0] window_start_min_q;
  logic [10:0] window_finish_min_q;
  logic        script_check_enable_q;
  logic        autowake_enable_q;
  logic        wear_budget_enable_q;
  logic [19:0] cycle_limit_q;
  logic [16:0] grace_cycles_q, grace_cycles_d;
  logic [19:0] span_cycles_q, span_cycles_d;
  logic [39:0] div_prod;
  logic        wr_en;
  aws_pkg::aws_reg_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = aws_pkg::aws_reg_e'(paddr[4:2]);

  // derived from the written limit so they change together with it
  assign div_prod       = 40'(pwdata[19:0]) * 40'(aws_pkg::Div10Mult);
  assign grace_cycles_d = div_prod[aws_pkg::Div10Shift +: 17];
  assign span_cycles_d  = pwdata[19:0] - 20'(grace_cycles_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shutdown_enable_q     <= 1'b0;
      idle_minutes_q        <= '0;
      window_start_min_q    <= '0;
      window_finish_min_q   <= '0;
      script_check_enable_q <= 1'b0;
      autowake_enable_q     <= 1'b0;
      wear_budget_enable_q  <= 1'b0;
      cycle_limit_q         <= 20'(aws_pkg::DefaultCycleLimit);
      grace_cycles_q        <= 17'(aws_pkg::DefaultGraceCycles);
      span_cycles_q         <= 20'(aws_pkg::DefaultSpan);
    end else begin
      if (wr_en) begin
        case (idx)
          aws_pkg::RegShutdownEnable:  shutdown_enable_q     <= pwdata[0];
          aws_pkg::RegIdleMinutes:     idle_minutes_q        <= pwdata[15:0];
          aws_pkg::RegWindowStartMin:  window_start_min_q    <= pwdata[10:0];
          aws_pkg::RegWindowFinishMin: window_finish_min_q   <= pwdata[10:0];
          aws_pkg::RegScriptCheck:     script_check_enable_q <= pwdata[0];
          aws_pkg::RegAutowake:        autowake_enable_q     <= pwdata[0];
          aws_pkg::RegWearBudget:      wear_budget_enable_q  <= pwdata[0];
          aws_pkg::RegCycleLimit: begin
            cycle_limit_q  <= pwdata[19:0];
            grace_cycles_q <= grace_cycles_d;
            span_cycles_q  <= span_cycles_d;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      aws_pkg::RegShutdownEnable:  prdata = 32'(shutdown_enable_q);
      aws_pkg::RegIdleMinutes:     prdata = 32'(idle_minutes_q);
      aws_pkg::RegWindowStartMin:  prdata = 32'(window_start_min_q);
      aws_pkg::RegWindowFinishMin: prdata = 32'(window_finish_min_q);
      aws_pkg::RegScriptCheck:     prdata = 32'(script_check_enable_q);
      aws_pkg::RegAutowake:        prdata = 32'(autowake_enable_q);
      aws_pkg::RegWearBudget:      prdata = 32'(wear_budget_enable_q);
      aws_pkg::RegCycleLimit:      prdata = 32'(cycle_limit_q);
      default:                     prdata = '0;
    endcase
  end

  assign cfg_o.shutdown_enable     = shutdown_enable_q;
  assign cfg_o.idle_minutes        = idle_minutes_q;
  assign cfg_o.window_start_min    = window_start_min_q;
  assign cfg_o.window_finish_min   = window_finish_min_q;
  assign cfg_o.script_check_enable = script_check_enable_q;
  assign cfg_o.autowake_enable     = autowake_enable_q;
  assign cfg_o.wear_budget_enable  = wear_budget_enable_q;
  assign cfg_o.cycle_limit         = cycle_limit_q;
  assign cfg_o.grace_cycles        = grace_cycles_q;
  assign cfg_o.span_cycles         = span_cycles_q;

endmodule

### hdl/aws_eval.sv
// Window, idle and wear-product evaluation stage with its pipeline register.
module aws_eval (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aws_pkg::aws_cfg_t  cfg_i,
  input  logic               valid_i,
  input  aws_pkg::aws_item_t item_i,
  output logic               ready_o,
  output logic               valid_o,
  output aws_pkg::aws_mid_t  mid_o,
  input  logic               ready_i
);

  logic               valid_q;
  aws_pkg::aws_mid_t  mid_q, mid_d;

  logic [16:0]        start_off, finish_off;
  logic signed [35:0] now_x, s_x, f_x, need_x, wake_x, next_out_x, next_busy_x;
  logic signed [35:0] poff_wait_x;
  logic [21:0]        need;
  logic signed [31:0] least, least_a, least_b, least_r, script_min;
  logic signed [32:0] nt1, nt2, nt;
  logic [31:0]        began;
  logic               use_default;

  always_comb begin
    start_off  = 17'(aws_pkg::mod_day(cfg_i.window_start_min)) * 17'd60;
    finish_off = 17'(aws_pkg::mod_day(cfg_i.window_finish_min)) * 17'd60;
    now_x      = $signed({4'b0, item_i.now_time});
    s_x        = $signed({4'b0, item_i.day_begin}) + $signed({19'b0, start_off});
    f_x        = $signed({4'b0, item_i.day_begin}) + $signed({19'b0, finish_off});

    need   = 22'(cfg_i.idle_minutes) * 22'd60;
    need_x = $signed({14'b0, need});

    least_a = (item_i.kbd_idle < item_i.mouse_idle) ? item_i.kbd_idle : item_i.mouse_idle;
    least_b = (item_i.system_idle < least_a) ? item_i.system_idle : least_a;
    least_r = $signed({1'b0, item_i.since_resume});
    least   = (least_r < least_b) ? least_r : least_b;
    script_min = ($signed({1'b0, item_i.script_idle}) < least) ?
                 $signed({1'b0, item_i.script_idle}) : least;
    nt1 = $signed({11'b0, need}) - $signed({least[31], least});
    nt2 = $signed({11'b0, need}) - $signed({script_min[31], script_min});
    nt  = (nt1 <= 0 && cfg_i.script_check_enable) ? nt2 : nt1;

    next_busy_x = now_x + $signed({{3{nt[32]}}, nt});
    next_out_x  = (s_x < f_x && now_x >= f_x) ? s_x + 36'(aws_pkg::SecsPerDay) : s_x;
    wake_x      = (now_x < f_x) ? f_x : f_x + 36'(aws_pkg::SecsPerDay);
    poff_wait_x = (need_x > 36'(aws_pkg::RetryWait)) ? need_x : 36'(aws_pkg::RetryWait);

    use_default = !item_i.board_date_known || (item_i.board_date > item_i.now_time);
    began       = use_default ? 32'(aws_pkg::DefaultBoardDate) : item_i.board_date;

    mid_d.enabled   = cfg_i.shutdown_enable;
    mid_d.in_window = (s_x < f_x && now_x >= s_x && now_x < f_x) ||
                      (s_x >= f_x && (now_x < f_x || now_x >= s_x));
    mid_d.busy      = nt > 0;
    mid_d.wear_quick_ok = !cfg_i.wear_budget_enable || !item_i.cycle_count_known ||
                          (item_i.cycle_count <= 20'(cfg_i.grace_cycles));
    mid_d.passed_neg  = began > item_i.now_time;
    mid_d.prod_budget = 52'(item_i.now_time - began) * 52'(cfg_i.span_cycles);
    mid_d.prod_need   = 48'(item_i.cycle_count) * 48'(aws_pkg::LifetimeSecs);
    mid_d.autowake    = cfg_i.autowake_enable;
    // wake may lie behind now when now is more than a day past day_begin
    mid_d.too_near    = (wake_x - now_x) < $signed(36'(aws_pkg::WakeGuard));
    mid_d.wake_time   = aws_pkg::sat32(wake_x);
    mid_d.next_pre    = aws_pkg::sat32(mid_d.in_window ? next_busy_x : next_out_x);
    mid_d.next_wear   = aws_pkg::sat32(now_x + 36'(aws_pkg::RetryWait));
    mid_d.next_near   = aws_pkg::sat32(now_x + 36'(aws_pkg::WakeGuard));
    mid_d.next_poff   = aws_pkg::sat32(now_x + poff_wait_x);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mid_q <= mid_d;
    end
  end

  assign valid_o = valid_q;
  assign mid_o   = mid_q;

endmodule

### hdl/aws_resolve.sv
// Wear budget compare, outcome selection and result register.
module aws_resolve (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  aws_pkg::aws_mid_t mid_i,
  output logic              ready_o,
  output logic              valid_o,
  output aws_pkg::aws_res_t res_o,
  input  logic              ready_i
);

  logic              valid_q;
  aws_pkg::aws_res_t res_q, res_d;
  logic              wear_ok;

  always_comb begin
    wear_ok = mid_i.wear_quick_ok ||
              (!mid_i.passed_neg && ({4'b0, mid_i.prod_need} <= mid_i.prod_budget));
    res_d.next_check = '0;
    res_d.power_off  = 1'b0;
    res_d.alarm_set  = 1'b0;
    res_d.alarm_time = '0;
    res_d.outcome    = aws_pkg::OutDisabled;
    if (!mid_i.enabled) begin
      res_d.outcome = aws_pkg::OutDisabled;
    end else if (!mid_i.in_window) begin
      res_d.outcome    = aws_pkg::OutOutside;
      res_d.next_check = mid_i.next_pre;
    end else if (mid_i.busy) begin
      res_d.outcome    = aws_pkg::OutBusy;
      res_d.next_check = mid_i.next_pre;
    end else if (!wear_ok) begin
      res_d.outcome    = aws_pkg::OutWearHold;
      res_d.next_check = mid_i.next_wear;
    end else if (mid_i.autowake && mid_i.too_near) begin
      res_d.outcome    = aws_pkg::OutWakeNear;
      res_d.next_check = mid_i.next_near;
    end else begin
      res_d.outcome    = aws_pkg::OutPowerOff;
      res_d.power_off  = 1'b1;
      res_d.next_check = mid_i.next_poff;
      res_d.alarm_set  = mid_i.autowake;
      res_d.alarm_time = mid_i.autowake ? mid_i.wake_time : '0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### hdl/autoshutdown_window_scheduler.sv
// Top level of the autoshutdown window scheduler.
//
// Usage: each word on in_i is one shutdown evaluation (current time, start of
// day, idle readings, power-cycle and board-date readings). For every word the
// block returns exactly one result word on out_o: next check time, power-off
// and alarm requests with the alarm time, and an outcome code.
// Configuration goes through the APB port (register i at byte address 4*i)
// and must be written only while no evaluation is in flight (not enforced).
// Path: each accepted word passes the input register, the evaluation register
// and the result register, in that order.
// Throughput: one word per cycle while out_o.ready is high; the multipliers of
// the wear budget sit in the evaluation stage with a register behind them.
// Stall: each stage holds its word while the stage after it is full and not
// draining, so up to three words are held while out_o.ready is low; in_i.ready
// drops only once all three are occupied.
// Reset: all stages empty, registers at their defaults (cycle limit 10000);
// the budget values derived from the cycle limit are updated with its write.
module autoshutdown_window_scheduler (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  aws_in_if.sink                    in_i,
  aws_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [aws_pkg::AddrW-1:0] paddr,
  input  logic [aws_pkg::DataW-1:0] pwdata,
  output logic [aws_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  aws_pkg::aws_cfg_t  cfg;
  aws_pkg::aws_item_t item_q, item_d;
  aws_pkg::aws_mid_t  mid;
  aws_pkg::aws_res_t  res;
  logic               in_valid_q;
  logic               eval_ready, mid_valid, res_ready, res_valid;

  aws_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign item_d.now_time          = in_i.now_time;
  assign item_d.day_begin         = in_i.day_begin;
  assign item_d.kbd_idle          = in_i.kbd_idle;
  assign item_d.mouse_idle        = in_i.mouse_idle;
  assign item_d.system_idle       = in_i.system_idle;
  assign item_d.since_resume      = in_i.since_resume;
  assign item_d.script_idle       = in_i.script_idle;
  assign item_d.cycle_count       = in_i.cycle_count;
  assign item_d.cycle_count_known = in_i.cycle_count_known;
  assign item_d.board_date        = in_i.board_date;
  assign item_d.board_date_known  = in_i.board_date_known;

  assign in_i.ready = !in_valid_q || eval_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= item_d;
    end
  end

  aws_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_valid_q),
    .item_i  (item_q),
    .ready_o (eval_ready),
    .valid_o (mid_valid),
    .mid_o   (mid),
    .ready_i (res_ready)
  );

  aws_resolve u_resolve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .mid_i   (mid),
    .ready_o (res_ready),
    .valid_o (res_valid),
    .res_o   (res),
    .ready_i (out_o.ready)
  );

  assign out_o.valid      = res_valid;
  assign out_o.next_check = res.next_check;
  assign out_o.power_off  = res.power_off;
  assign out_o.alarm_set  = res.alarm_set;
  assign out_o.alarm_time = res.alarm_time;
  assign out_o.outcome    = res.outcome;

  a_backpressure_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without output backpressure");

  a_alarm_with_poff : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.alarm_set) |-> out_o.power_off)
    else $error("alarm requested without power off");

  a_poff_outcome : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.power_off == (out_o.outcome == aws_pkg::OutPowerOff)))
    else $error("power off flag disagrees with outcome");

  a_disabled_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.outcome == aws_pkg::OutDisabled) |->
    (out_o.next_check == '0 && !out_o.alarm_set))
    else $error("disabled result carries a schedule");

endmodule

### verif/aws_tb_pkg.sv
// Scoreboard for the autoshutdown window scheduler: predicts and checks result words.
package aws_tb_pkg;
  import aws_pkg::*;

  localparam longint MinsDay    = 1440;
  localparam longint SecsDay    = 86400;
  localparam longint LifeSecs   = 7 * 365 * SecsDay;
  localparam longint BoardEpoch = 804582000;
  localparam longint WakeGap    = 180;
  localparam longint RetryGap   = 300;
  localparam longint U32Max     = 'hFFFF_FFFF;
  localparam longint IdleMax    = 'h7FFF_FFFF;

  class sched_scoreboard;
    logic        enable;
    logic [15:0] idle_min;
    logic [10:0] start_min;
    logic [10:0] finish_min;
    logic        script_en;
    logic        wake_en;
    logic        wear_en;
    logic [19:0] cyc_limit;
    aws_res_t    expected_q[$];
    int          errors;

    function new();
      enable     = 1'b0;
      idle_min   = '0;
      start_min  = '0;
      finish_min = '0;
      script_en  = 1'b0;
      wake_en    = 1'b0;
      wear_en    = 1'b0;
      cyc_limit  = 20'(DefaultCycleLimit);
      errors     = 0;
    endfunction

    function void write_reg(aws_reg_e r, logic [31:0] v);
      case (r)
        RegShutdownEnable:  enable     = v[0];
        RegIdleMinutes:     idle_min   = v[15:0];
        RegWindowStartMin:  start_min  = v[10:0];
        RegWindowFinishMin: finish_min = v[10:0];
        RegScriptCheck:     script_en  = v[0];
        RegAutowake:        wake_en    = v[0];
        RegWearBudget:      wear_en    = v[0];
        RegCycleLimit:      cyc_limit  = v[19:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] clamp32(longint v);
      if (v < 0) return '0;
      if (v > U32Max) return '1;
      return v[31:0];
    endfunction

    // power-cycle wear budget: free cycles first, then a share growing with board age
    function bit wear_allows(longint now, aws_item_t w);
      longint lim, free_cyc, cnt, began, passed, budget;
      if (!wear_en) return 1'b1;
      lim = cyc_limit;
      free_cyc = lim / 10;
      cnt = w.cycle_count;
      if (!w.cycle_count_known || cnt <= free_cyc) return 1'b1;
      began = w.board_date;
      if (!w.board_date_known || began > now) began = BoardEpoch;
      passed = now - began;
      budget = (passed * (lim - free_cyc)) / LifeSecs;
      return cnt <= budget;
    endfunction

    function aws_res_t schedule(aws_item_t w);
      aws_res_t r;
      longint now, day, need, s, f, least, v, nt, nxt, wake;
      r = '0;
      r.outcome = OutDisabled;
      if (!enable) return r;
      now  = w.now_time;
      day  = w.day_begin;
      need = idle_min;
      need = need * 60;
      s = start_min;
      s = day + (s % MinsDay) * 60;
      f = finish_min;
      f = day + (f % MinsDay) * 60;
      if ((s < f && now >= s && now < f) || (s >= f && (now < f || now >= s))) begin
        least = $signed(w.kbd_idle);
        v = $signed(w.mouse_idle);
        if (v < least) least = v;
        v = $signed(w.system_idle);
        if (v < least) least = v;
        v = w.since_resume;
        if (v < least) least = v;
        nt = need - least;
        if (nt <= 0 && script_en) begin
          v = w.script_idle;
          if (v > least) v = least;
          nt = need - v;
        end
        if (nt > 0) begin
          nxt = now + nt;
          r.outcome = OutBusy;
        end else if (!wear_allows(now, w)) begin
          nxt = now + RetryGap;
          r.outcome = OutWearHold;
        end else begin
          r.outcome = OutPowerOff;
          if (wake_en) begin
            wake = (now < f) ? f : f + SecsDay;
            if (wake - now < WakeGap) begin
              nxt = now + WakeGap;
              r.outcome = OutWakeNear;
            end else begin
              r.alarm_set  = 1'b1;
              r.alarm_time = clamp32(wake);
            end
          end
          if (r.outcome == OutPowerOff) begin
            r.power_off = 1'b1;
            nxt = now + ((need > RetryGap) ? need : RetryGap);
          end
        end
      end else begin
        r.outcome = OutOutside;
        nxt = (s < f && now >= f) ? s + SecsDay : s;
      end
      r.next_check = clamp32(nxt);
      return r;
    endfunction

    function void note_eval(aws_item_t w);
      expected_q.push_back(schedule(w));
    endfunction

    function void check_field(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(aws_res_t got);
      aws_res_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, next_check %0h outcome %0d",
                 $time, got.next_check, got.outcome);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      check_field("next_check", e.next_check, got.next_check);
      check_field("power_off", 32'(e.power_off), 32'(got.power_off));
      check_field("alarm_set", 32'(e.alarm_set), 32'(got.alarm_set));
      check_field("alarm_time", e.alarm_time, got.alarm_time);
      check_field("outcome", 32'(e.outcome), 32'(got.outcome));
    endfunction
  endclass

endpackage

### verif/tb_autoshutdown_window_scheduler.sv
// Testbench top: drives evaluation words and register writes, checks every result word.
module tb_autoshutdown_window_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import aws_pkg::*;
  import aws_tb_pkg::*;

  localparam int          StallLimit = 2000;
  localparam int unsigned RefDay     = 32'd1_000_000_000;
  localparam int unsigned YearSecs   = 32'd31_536_000;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  aws_in_if  in_if ();
  aws_out_if out_if ();

  autoshutdown_window_scheduler uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sched_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int stall_cycles;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin : monitor
    aws_item_t seen;
    aws_res_t  got;
    bit        moved;
    if (rst_ni) begin
      moved = psel;
      if (in_if.valid && in_if.ready) begin
        seen.now_time          = in_if.now_time;
        seen.day_begin         = in_if.day_begin;
        seen.kbd_idle          = in_if.kbd_idle;
        seen.mouse_idle        = in_if.mouse_idle;
        seen.system_idle       = in_if.system_idle;
        seen.since_resume      = in_if.since_resume;
        seen.script_idle       = in_if.script_idle;
        seen.cycle_count       = in_if.cycle_count;
        seen.cycle_count_known = in_if.cycle_count_known;
        seen.board_date        = in_if.board_date;
        seen.board_date_known  = in_if.board_date_known;
        sb.note_eval(seen);
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        got.next_check = out_if.next_check;
        got.power_off  = out_if.power_off;
        got.alarm_set  = out_if.alarm_set;
        got.alarm_time = out_if.alarm_time;
        got.outcome    = aws_outcome_e'(out_if.outcome);
        sb.check_result(got);
        moved = 1'b1;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("FAIL autoshutdown_window_scheduler");
        $finish;
      end
    end
  end

  task automatic send_eval(input aws_item_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.now_time          <= w.now_time;
    in_if.day_begin         <= w.day_begin;
    in_if.kbd_idle          <= w.kbd_idle;
    in_if.mouse_idle        <= w.mouse_idle;
    in_if.system_idle       <= w.system_idle;
    in_if.since_resume      <= w.since_resume;
    in_if.script_idle       <= w.script_idle;
    in_if.cycle_count       <= w.cycle_count;
    in_if.cycle_count_known <= w.cycle_count_known;
    in_if.board_date        <= w.board_date;
    in_if.board_date_known  <= w.board_date_known;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // stop sending and wait for every outstanding result word
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // leaves psel/penable high; the caller closes the transfer sequence
  task automatic apb_write(input aws_reg_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(r, v);
  endtask

  task automatic set_config(input logic en, input logic [15:0] idle,
                            input logic [10:0] st, input logic [10:0] fi,
                            input logic sc, input logic wk, input logic wr,
                            input logic [19:0] lim);
    drain();
    apb_write(RegShutdownEnable, 32'(en));
    apb_write(RegIdleMinutes, 32'(idle));
    apb_write(RegWindowStartMin, 32'(st));
    apb_write(RegWindowFinishMin, 32'(fi));
    apb_write(RegScriptCheck, 32'(sc));
    apb_write(RegAutowake, 32'(wk));
    apb_write(RegWearBudget, 32'(wr));
    apb_write(RegCycleLimit, 32'(lim));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  function automatic aws_item_t mk_eval(
    logic [31:0] now, logic [31:0] day,
    logic signed [31:0] kbd, logic signed [31:0] mouse, logic signed [31:0] sys,
    logic [30:0] resume, logic [30:0] script,
    logic [19:0] cnt, logic cnt_ok, logic [31:0] bdate, logic bdate_ok);
    aws_item_t w;
    w.now_time          = now;
    w.day_begin         = day;
    w.kbd_idle          = kbd;
    w.mouse_idle        = mouse;
    w.system_idle       = sys;
    w.since_resume      = resume;
    w.script_idle       = script;
    w.cycle_count       = cnt;
    w.cycle_count_known = cnt_ok;
    w.board_date        = bdate;
    w.board_date_known  = bdate_ok;
    return w;
  endfunction

  function automatic logic [10:0] pick_minute();
    case ($urandom_range(7))
      0:       return 11'd0;
      1:       return 11'd1439;
      2:       return 11'd1440;
      3:       return 11'd2047;
      default: return 11'($urandom_range(2047));
    endcase
  endfunction

  // idle reading near base, sometimes unknown or anywhere in range
  function automatic logic [31:0] idle_near(longint base, bit may_be_unknown);
    longint v;
    if (may_be_unknown && $urandom_range(11) == 0) return '1;
    if ($urandom_range(19) == 0) return $urandom_range(32'h7FFF_FFFF);
    v = base;
    if ($urandom_range(2) != 0) v = v + $urandom_range(1000);
    if (v < 0) v = 0;
    if (v > IdleMax) v = IdleMax;
    return v[31:0];
  endfunction

  // evaluation aimed at the window edges and the idle threshold
  function automatic aws_item_t random_eval();
    aws_item_t w;
    longint    need, st, fi, off, base, lim;
    need = sb.idle_min;
    need = need * 60;
    st = sb.start_min;
    st = (st % MinsDay) * 60;
    fi = sb.finish_min;
    fi = (fi % MinsDay) * 60;
    w.day_begin = $urandom();
    case ($urandom_range(9))
      0, 1, 2: off = $urandom_range(86399);
      3, 4: begin
        off = $urandom_range(400);
        off = st + off - 200;
      end
      5, 6: begin
        off = $urandom_range(600);
        off = fi + off - 300;
      end
      7: begin
        off = $urandom_range(3600);
        off = fi - off;
      end
      8:       off = $urandom_range(172799);
      default: off = $urandom();
    endcase
    w.now_time = 32'(w.day_begin + off);
    case ($urandom_range(9))
      0: base = $urandom_range(32'h7FFF_FFFF);
      1, 2: begin
        off = $urandom_range(299);
        base = need - 1 - off;
      end
      default: begin
        off = $urandom_range(600);
        base = need + off;
      end
    endcase
    if (base < 0) base = 0;
    w.kbd_idle     = idle_near(base, 1'b1);
    w.mouse_idle   = idle_near(base, 1'b1);
    w.system_idle  = idle_near(base, 1'b1);
    w.since_resume = 31'(idle_near(base, 1'b0));
    off = $urandom_range(600);
    off = need + off - 300;
    w.script_idle = 31'(idle_near(off, 1'b0));
    lim = sb.cyc_limit;
    case ($urandom_range(3))
      0:       off = $urandom_range(32'(lim / 10));
      1:       off = $urandom_range(32'(lim));
      2:       off = $urandom_range(1000000);
      default: off = $urandom_range(2000);
    endcase
    if (off > 1000000) off = 1000000;
    w.cycle_count       = 20'(off);
    w.cycle_count_known = ($urandom_range(6) != 0);
    case ($urandom_range(3))
      0, 1: w.board_date = w.now_time - $urandom_range(32'(LifeSecs));
      2:    w.board_date = w.now_time + $urandom_range(1000000, 1);
      default: w.board_date = $urandom();
    endcase
    w.board_date_known = ($urandom_range(6) != 0);
    return w;
  endfunction

  task automatic random_config();
    logic [15:0] idle;
    logic [19:0] lim;
    case ($urandom_range(4))
      0:       idle = '0;
      1:       idle = '1;
      2:       idle = 16'($urandom_range(10));
      3:       idle = 16'($urandom_range(120));
      default: idle = 16'($urandom());
    endcase
    case ($urandom_range(6))
      0:       lim = '0;
      1:       lim = 20'd10000;
      2:       lim = 20'd1000000;
      3:       lim = '1;
      4:       lim = 20'($urandom_range(100));
      default: lim = 20'($urandom_range(1000000));
    endcase
    set_config(($urandom_range(9) != 0), idle, pick_minute(), pick_minute(),
               1'($urandom_range(1)), 1'($urandom_range(1)),
               ($urandom_range(3) != 0), lim);
  endtask

  task automatic run_directed();
    // registers at reset: block disabled
    send_eval(mk_eval('1, '1, -1, -1, -1, '1, '1, 20'd1000000, 1'b1, '1, 1'b1));
    send_eval(mk_eval('0, '0, 0, 0, 0, '0, '0, '0, 1'b0, '0, 1'b0));

    // window 01:00..05:00, ten idle minutes, all options on
    set_config(1'b1, 16'd10, 11'd60, 11'd300, 1'b1, 1'b1, 1'b1, 20'd10000);
    send_eval(mk_eval(RefDay + 1800, RefDay, 1000, 1000, 1000, 1000, 5000,
                      20'd500, 1'b1, RefDay - YearSecs, 1'b1));
    send_eval(mk_eval(RefDay + 24000, RefDay, 1000, 1000, 1000, 1000, 5000,
                      20'd500, 1'b1, RefDay - YearSecs, 1'b1));
    send_eval(mk_eval(RefDay + 7200, RefDay, 1000, 1000, 1000, 1000, 5000,
                      20'd500, 1'b1, RefDay - YearSecs, 1'b1));
    send_eval(mk_eval(RefDay + 7200, RefDay, -1, 1000, 1000, 1000, 5000,
                      20'd500, 1'b1, RefDay - YearSecs, 1'b1));
    send_eval(mk_eval(RefDay + 7200, RefDay, 1000, 1000, 1000, 1000, 100,
                      20'd500, 1'b1, RefDay - YearSecs, 1'b1));
    send_eval(mk_eval(RefDay + 7200, RefDay, 1000, 1000, 1000, 1000, 5000,
                      20'd5000, 1'b1, RefDay + 7200 - YearSecs, 1'b1));
    send_eval(mk_eval(RefDay + 7200, RefDay, 1000, 1000, 1000, 1000, 5000,
                      20'd5000, 1'b0, RefDay - YearSecs, 1'b1));
    send_eval(mk_eval(RefDay + 7200, RefDay, 1000, 1000, 1000, 1000, 5000,
                      20'd5000, 1'b1, '0, 1'b0));
    // board date in the future falls back to the default
    send_eval(mk_eval(RefDay + 7200, RefDay, 1000, 1000, 1000, 1000, 5000,
                      20'd9000, 1'b1, RefDay + 8200, 1'b1));
    // negative life passed
    send_eval(mk_eval(32'd7200, '0, 1000, 1000, 1000, 1000, 5000,
                      20'd2000, 1'b1, '0, 1'b0));
    // alarm closer than the guard
    send_eval(mk_eval(RefDay + 17900, RefDay, 1000, 1000, 1000, 1000, 5000,
                      20'd500, 1'b1, RefDay - YearSecs, 1'b1));
    send_eval(mk_eval(RefDay + 7200, RefDay, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, '1, '1, '0, 1'b1, '0, 1'b1));
    send_eval(mk_eval(RefDay + 7200, RefDay, 1000, 1000, 1000, '0, 5000,
                      20'd500, 1'b1, RefDay - YearSecs, 1'b1));

    // wrapped window, minutes past a day, zero idle period, zero cycle limit
    set_config(1'b1, 16'd0, 11'd2047, 11'd1560, 1'b0, 1'b1, 1'b0, 20'd0);
    send_eval(mk_eval(RefDay + 100, RefDay, 0, 0, 0, '0, '0, '0, 1'b1, '0, 1'b1));
    send_eval(mk_eval(RefDay + 10000, RefDay, 0, 0, 0, '0, '0, '0, 1'b1, '0, 1'b1));
    send_eval(mk_eval(RefDay + 50000, RefDay, 0, 0, 0, '0, '0, '0, 1'b1, '0, 1'b1));
    send_eval(mk_eval(32'hFFFF_0000 + 50000, 32'hFFFF_0000, 0, 0, 0, '0, '0,
                      '0, 1'b1, '0, 1'b1));
    send_eval(mk_eval('0, '0, 0, 0, 0, '0, '0, '0, 1'b0, '0, 1'b0));

    // always open, longest idle period, cycle limit 1000000: saturation
    set_config(1'b1, 16'hFFFF, 11'd0, 11'd0, 1'b1, 1'b0, 1'b1, 20'd1000000);
    send_eval(mk_eval(32'hFFFF_FF00, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, '1, '1, '0, 1'b1, '0, 1'b1));
    send_eval(mk_eval(32'hFFFF_FF00, 32'hFFFF_0000, -1, -1, -1, '1, '1,
                      '0, 1'b1, '0, 1'b1));
    send_eval(mk_eval('1, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, '1, '1, 20'd1000000, 1'b1, '0, 1'b1));
  endtask

  initial begin
    sb = new();
    clk_i   = 1'b0;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_if.valid             = 1'b0;
    in_if.now_time          = '0;
    in_if.day_begin         = '0;
    in_if.kbd_idle          = '0;
    in_if.mouse_idle        = '0;
    in_if.system_idle       = '0;
    in_if.since_resume      = '0;
    in_if.script_idle       = '0;
    in_if.cycle_count       = '0;
    in_if.cycle_count_known = 1'b0;
    in_if.board_date        = '0;
    in_if.board_date_known  = 1'b0;
    out_if.ready            = 1'b0;
    tx_idle_pct  = 37;
    rx_idle_pct  = 47;
    stall_cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (int k = 0; k < 12; k++) begin
      if (k == 4) begin
        tx_idle_pct = 47;
        rx_idle_pct = 37;
      end else if (k == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_config();
      repeat (140) send_eval(random_eval());
    end
    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS autoshutdown_window_scheduler");
    end else begin
      $display("FAIL autoshutdown_window_scheduler");
    end
    $finish;
  end

endmodule
